FILE: rtl/core/feature_vector_encoder_defines.svh
// Assertion macros shared by the feature vector encoder RTL.
`ifndef FEATURE_VECTOR_ENCODER_DEFINES_SVH
`define FEATURE_VECTOR_ENCODER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define FVE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define FVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fve_pkg.sv
// Types, codes and constants shared by the feature vector encoder modules.
package fve_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH   = 2;

    // Encoding kinds on the input.
    localparam logic [2:0] FUNC_FRAC   = 3'd0;
    localparam logic [2:0] FUNC_BIN    = 3'd1;
    localparam logic [2:0] FUNC_THERM  = 3'd2;
    localparam logic [2:0] FUNC_SQRT   = 3'd3;
    localparam logic [2:0] FUNC_ONEHOT = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_KIND  = 2'd2;

    // Commands handed from the front to the back.
    localparam logic [2:0] CMD_FIX    = 3'd0;
    localparam logic [2:0] CMD_NA     = 3'd1;
    localparam logic [2:0] CMD_BIN    = 3'd2;
    localparam logic [2:0] CMD_THERM  = 3'd3;
    localparam logic [2:0] CMD_SQRT   = 3'd4;
    localparam logic [2:0] CMD_ONEHOT = 3'd5;
    localparam logic [2:0] CMD_FRAC   = 3'd6;

    // Element generation modes in the back.
    localparam logic [2:0] MODE_FIX    = 3'd0;
    localparam logic [2:0] MODE_NA     = 3'd1;
    localparam logic [2:0] MODE_BIN    = 3'd2;
    localparam logic [2:0] MODE_THERM  = 3'd3;
    localparam logic [2:0] MODE_ONEHOT = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] value;
        logic        value_na;
        logic [6:0]  out_width;
        logic [15:0] max_value;
    } in_t;

    typedef struct packed {
        logic [14:0] element;
        logic        element_na;
        logic [1:0]  status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] value;
        logic [15:0] max_value;
        logic [6:0]  width;
        logic        na;
        logic [1:0]  status;
    } cmd_t;

endpackage

FILE: rtl/core/fve_front.sv
// Front end: accepts input beats and classifies them into back-end commands.
module fve_front #(
    parameter int MAX_WIDTH = fve_pkg::MAX_WIDTH_DEF
) (
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fve_pkg::in_t  s_data,
    input  logic          q_full,
    output logic          push,
    output fve_pkg::cmd_t cmd
);

    logic [6:0] width_sat;
    logic       drop;

    assign s_ready = aresetn && !q_full;

    always_comb begin
        if (s_data.out_width > 7'(MAX_WIDTH)) begin
            width_sat = 7'(MAX_WIDTH);
        end else begin
            width_sat = s_data.out_width;
        end

        cmd.value     = s_data.value;
        cmd.max_value = s_data.max_value;
        cmd.width     = width_sat;
        cmd.na        = 1'b0;
        cmd.status    = fve_pkg::STAT_OK;
        cmd.op        = fve_pkg::CMD_FIX;
        drop          = 1'b0;

        if (s_data.value_na) begin
            if (s_data.func == fve_pkg::FUNC_FRAC) begin
                cmd.op    = fve_pkg::CMD_FIX;
                cmd.na    = 1'b1;
                cmd.width = 7'd1;
            end else begin
                cmd.op = fve_pkg::CMD_NA;
                drop   = (width_sat == 7'd0);
            end
        end else if (s_data.value > s_data.max_value) begin
            cmd.op     = fve_pkg::CMD_FIX;
            cmd.status = fve_pkg::STAT_RANGE;
            cmd.width  = 7'd1;
        end else begin
            case (s_data.func)
                fve_pkg::FUNC_FRAC: begin
                    cmd.op    = fve_pkg::CMD_FRAC;
                    cmd.width = 7'd1;
                end
                fve_pkg::FUNC_BIN:    cmd.op = fve_pkg::CMD_BIN;
                fve_pkg::FUNC_THERM:  cmd.op = fve_pkg::CMD_THERM;
                fve_pkg::FUNC_SQRT:   cmd.op = fve_pkg::CMD_SQRT;
                fve_pkg::FUNC_ONEHOT: cmd.op = fve_pkg::CMD_ONEHOT;
                default: begin
                    cmd.op     = fve_pkg::CMD_FIX;
                    cmd.status = fve_pkg::STAT_KIND;
                    cmd.width  = 7'd1;
                end
            endcase
            // An empty run produces nothing at all.
            if (cmd.op != fve_pkg::CMD_FIX && cmd.op != fve_pkg::CMD_FRAC) begin
                drop = (width_sat == 7'd0);
            end
        end
    end

    assign push = s_valid && s_ready && !drop;

endmodule

FILE: rtl/core/fve_queue.sv
// Small command queue between the front and back ends.
module fve_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  fve_pkg::cmd_t push_data,
    input  logic          pop,
    output fve_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    localparam int PW = (fve_pkg::QUEUE_DEPTH > 1) ? $clog2(fve_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(fve_pkg::QUEUE_DEPTH + 1);

    fve_pkg::cmd_t entry_reg [fve_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(fve_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == CW'(0));
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(fve_pkg::QUEUE_DEPTH - 1)) ?
                          PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(fve_pkg::QUEUE_DEPTH - 1)) ?
                          PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/fve_back.sv
// Back end: serial divide and square root, then element-by-element emission.
`include "feature_vector_encoder_defines.svh"

module fve_back #(
    parameter int MAX_WIDTH = fve_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = fve_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  fve_pkg::cmd_t q_data,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output fve_pkg::out_t m_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int QW = FRAC_BITS + 1;
    localparam int SW = $clog2(FRAC_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    mode_reg, mode_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] width_reg, width_next;
    logic [15:0]   value_reg, value_next;
    logic [15:0]   max_reg, max_next;
    logic [15:0]   ones_reg, ones_next;
    logic [15:0]   rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [SW-1:0] step_reg, step_next;
    logic [7:0]    root_reg, root_next;
    logic [7:0]    bit_reg, bit_next;
    logic          na_reg, na_next;
    logic [1:0]    status_reg, status_next;
    logic          m_valid_reg, m_valid_next;
    fve_pkg::out_t m_data_reg;
    fve_pkg::out_t out_next;
    logic          out_load;

    logic [16:0]   shifted;
    logic          div_ge;
    logic [7:0]    trial;
    logic [15:0]   trial_sq;
    logic [15:0]   bin_shift;
    logic          elem_bit;
    logic          q0;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // One restoring-division step and one square-root trial per cycle.
    assign shifted   = {rem_reg, 1'b0};
    assign div_ge    = (shifted >= {1'b0, max_reg});
    assign trial     = root_reg | bit_reg;
    assign trial_sq  = trial * trial;
    assign bin_shift = value_reg >> cnt_reg;
    assign q0        = (q_data.value >= q_data.max_value);

    always_comb begin
        case (mode_reg)
            fve_pkg::MODE_BIN:    elem_bit = bin_shift[0];
            fve_pkg::MODE_THERM:  elem_bit = (16'(cnt_reg) < ones_reg);
            fve_pkg::MODE_ONEHOT: elem_bit = (16'(cnt_reg) == value_reg);
            default:              elem_bit = 1'b0;
        endcase

        out_next.element    = (mode_reg == fve_pkg::MODE_FIX) ? 15'(quo_reg) : 15'(elem_bit);
        out_next.element_na = (mode_reg == fve_pkg::MODE_NA) ? 1'b1 : na_reg;
        out_next.status     = status_reg;
        out_next.last       = ((cnt_reg + CW'(1)) == width_reg);
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        width_next  = width_reg;
        value_next  = value_reg;
        max_next    = max_reg;
        ones_next   = ones_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        root_next   = root_reg;
        bit_next    = bit_reg;
        na_next     = na_reg;
        status_next = status_reg;
        pop         = 1'b0;
        out_load    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop         = 1'b1;
                    cnt_next    = '0;
                    width_next  = CW'(q_data.width);
                    value_next  = q_data.value;
                    max_next    = q_data.max_value;
                    ones_next   = q_data.value;
                    na_next     = q_data.na;
                    status_next = q_data.status;
                    quo_next    = '0;
                    state_next  = ST_EMIT;
                    case (q_data.op)
                        fve_pkg::CMD_FIX:    mode_next = fve_pkg::MODE_FIX;
                        fve_pkg::CMD_NA:     mode_next = fve_pkg::MODE_NA;
                        fve_pkg::CMD_BIN:    mode_next = fve_pkg::MODE_BIN;
                        fve_pkg::CMD_THERM:  mode_next = fve_pkg::MODE_THERM;
                        fve_pkg::CMD_ONEHOT: mode_next = fve_pkg::MODE_ONEHOT;
                        fve_pkg::CMD_SQRT: begin
                            mode_next  = fve_pkg::MODE_THERM;
                            root_next  = '0;
                            bit_next   = 8'h80;
                            state_next = ST_SQRT;
                        end
                        fve_pkg::CMD_FRAC: begin
                            mode_next = fve_pkg::MODE_FIX;
                            // A zero maximum only passes with a zero value; the result is 0.
                            if (q_data.max_value != 16'd0) begin
                                quo_next   = QW'(q0);
                                rem_next   = q0 ? (q_data.value - q_data.max_value)
                                                : q_data.value;
                                step_next  = SW'(FRAC_BITS);
                                state_next = ST_DIV;
                            end
                        end
                        default: mode_next = fve_pkg::MODE_FIX;
                    endcase
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? 16'(shifted - {1'b0, max_reg}) : shifted[15:0];
                quo_next  = {quo_reg[QW-2:0], div_ge};
                step_next = step_reg - SW'(1);
                if (step_reg == SW'(1)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_SQRT: begin
                if (trial_sq <= value_reg) begin
                    root_next = trial;
                end
                bit_next = bit_reg >> 1;
                if (bit_reg[0]) begin
                    ones_next  = (trial_sq <= value_reg) ? 16'(trial) : 16'(root_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                    if (out_next.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        cnt_reg    <= cnt_next;
        width_reg  <= width_next;
        value_reg  <= value_next;
        max_reg    <= max_next;
        ones_reg   <= ones_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        na_reg     <= na_next;
        status_reg <= status_next;
        if (out_load) begin
            m_data_reg <= out_next;
        end
    end

    `FVE_ASSERT_ALWAYS(a_pop_only_idle, !(pop && (state_reg != ST_IDLE)), "pop outside idle")
    `FVE_ASSERT_ALWAYS(a_no_load_busy, !(out_load && (state_reg != ST_EMIT)), "beat loaded while computing")
    `FVE_ASSERT_ALWAYS(a_cnt_in_run, !((state_reg == ST_EMIT) && (cnt_reg >= width_reg)), "element index past run")
    `FVE_ASSERT_NEXT(a_last_ends_run, out_load && out_next.last, (state_reg == ST_IDLE) && m_valid_reg, "run did not end after last beat")

endmodule

FILE: rtl/core/feature_vector_encoder.sv
// Top level of the feature vector encoder.
//
// Input channel s_*: one beat carries an attribute value with its encoding
// kind, output width and maximum. Result channel m_*: a run of element beats
// for that input, with last set on the final beat. Both use valid/ready.
// A front classifies each input beat into a command and pushes it into a
// two-entry queue; a back end pops commands and produces the elements.
// The bit kinds go straight to emission; the square-root thermometer first
// takes eight trial steps of an 8x8 multiplier, and the fraction kind first
// runs its restoring divide, one step per cycle. A run is then emitted one
// beat per cycle when the receiver is ready, and the back end pops the next
// command only after the last beat of the run is loaded.
// Items with an empty run produce no beats and take no back-end time.
// Reset (aresetn low, synchronous) empties the queue, drops any run in flight
// and clears m_valid. When m_ready is low, the output register holds its
// beat, the back end waits, and the front keeps accepting until the queue
// is full.
module feature_vector_encoder #(
    parameter int MAX_WIDTH = fve_pkg::MAX_WIDTH_DEF,
    parameter int FRAC_BITS = fve_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fve_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output fve_pkg::out_t m_data
);

    fve_pkg::cmd_t push_cmd;
    fve_pkg::cmd_t pop_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    fve_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push),
        .cmd     (push_cmd)
    );

    fve_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    fve_back #(
        .MAX_WIDTH(MAX_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (pop_cmd),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the feature vector encoder: directed and random inputs.
module testbench;

    localparam logic [2:0] FUNC_BAD_FIRST = fve_pkg::FUNC_ONEHOT + 3'd1;
    localparam logic [2:0] FUNC_BAD_LAST  = 3'b111;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 18;

    // Predicts the element run of each accepted input and checks result beats in order.
    class element_scoreboard;
        fve_pkg::out_t expected_elements[$];
        int items_seen;
        int beats_seen;
        int errors;
        int na_count;
        int range_count;
        int bad_kind_count;
        int kind_count[8];

        function int unsigned int_sqrt(logic [15:0] v);
            int unsigned root;
            int unsigned trial;
            root = 0;
            for (int b = 7; b >= 0; b--) begin
                trial = root | (32'd1 << b);
                if (trial * trial <= v) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void queue_element(logic [14:0] elem, logic na, logic [1:0] st,
                                    logic last);
            fve_pkg::out_t e;
            e.element    = elem;
            e.element_na = na;
            e.status     = st;
            e.last       = last;
            expected_elements.insert(expected_elements.size(), e);
        endfunction

        function void note_input(fve_pkg::in_t beat);
            int width;
            int ones;
            logic [29:0] scaled;
            logic bit_on;
            items_seen++;
            kind_count[beat.func]++;
            width = (beat.out_width > fve_pkg::MAX_WIDTH_DEF) ? fve_pkg::MAX_WIDTH_DEF
                                                              : int'(beat.out_width);

            // Not available wins over every other check, invalid kinds included.
            if (beat.value_na) begin
                na_count++;
                if (beat.func == fve_pkg::FUNC_FRAC) begin
                    queue_element(15'd0, 1'b1, fve_pkg::STAT_OK, 1'b1);
                end else begin
                    for (int i = 0; i < width; i++) begin
                        queue_element(15'd0, 1'b1, fve_pkg::STAT_OK, i == width - 1);
                    end
                end
                return;
            end

            if (beat.value > beat.max_value) begin
                range_count++;
                queue_element(15'd0, 1'b0, fve_pkg::STAT_RANGE, 1'b1);
                return;
            end

            if (beat.func == fve_pkg::FUNC_FRAC) begin
                scaled = 30'd0;
                if (beat.max_value != 16'd0) begin
                    scaled = (30'(beat.value) << fve_pkg::FRAC_BITS_DEF) /
                             30'(beat.max_value);
                end
                queue_element(scaled[14:0], 1'b0, fve_pkg::STAT_OK, 1'b1);
                return;
            end

            if (beat.func > fve_pkg::FUNC_ONEHOT) begin
                bad_kind_count++;
                queue_element(15'd0, 1'b0, fve_pkg::STAT_KIND, 1'b1);
                return;
            end

            ones = (beat.func == fve_pkg::FUNC_SQRT) ? int'(int_sqrt(beat.value))
                                                     : int'(beat.value);
            if (ones > width) begin
                ones = width;
            end
            for (int i = 0; i < width; i++) begin
                if (beat.func == fve_pkg::FUNC_BIN) begin
                    bit_on = (i < 16) ? ((beat.value >> i) & 16'd1) != 16'd0 : 1'b0;
                end else if (beat.func == fve_pkg::FUNC_ONEHOT) begin
                    bit_on = (i == int'(beat.value));
                end else begin
                    bit_on = (i < ones);
                end
                queue_element({14'd0, bit_on}, 1'b0, fve_pkg::STAT_OK, i == width - 1);
            end
        endfunction

        function void check_result(fve_pkg::out_t got);
            fve_pkg::out_t want;
            if (expected_elements.size() == 0) begin
                $error("unexpected element beat: element %0d na %0d status %0d last %0d",
                       got.element, got.element_na, got.status, got.last);
                errors++;
                return;
            end
            want = expected_elements.pop_front();
            beats_seen++;
            if (got.element !== want.element) begin
                $error("element: expected %0d, got %0d", want.element, got.element);
                errors++;
            end
            if (got.element_na !== want.element_na) begin
                $error("element_na: expected %0d, got %0d", want.element_na, got.element_na);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_elements.size();
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    fve_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    fve_pkg::out_t m_data;
    logic          calm = 1'b0;
    int            cycle_count = 0;

    element_scoreboard sb = new();

    feature_vector_encoder DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d elements outstanding.",
                     cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Presents one input beat, possibly after a random gap, and returns at the
    // edge where it is taken.
    task automatic send_beat(input logic [2:0] func, input logic [15:0] value,
                             input logic na, input logic [6:0] width,
                             input logic [15:0] max_value);
        fve_pkg::in_t beat;
        beat = '{func, value, na, width, max_value};
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [2:0]  func;
        logic [15:0] value;
        logic        na;
        logic [6:0]  width;
        logic [15:0] max_value;
        int          roll;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Fraction: zero, full scale, flooring, and zero over zero.
        send_beat(fve_pkg::FUNC_FRAC, 16'd0, 1'b0, 7'd1, 16'd1);
        send_beat(fve_pkg::FUNC_FRAC, 16'hFFFF, 1'b0, 7'd1, 16'hFFFF);
        send_beat(fve_pkg::FUNC_FRAC, 16'd1, 1'b0, 7'd0, 16'hFFFF);
        send_beat(fve_pkg::FUNC_FRAC, 16'd32767, 1'b0, 7'd64, 16'hFFFF);
        send_beat(fve_pkg::FUNC_FRAC, 16'd0, 1'b0, 7'd5, 16'd0);
        // Binary, including bits past the top of the value and a saturated width.
        send_beat(fve_pkg::FUNC_BIN, 16'hA5A5, 1'b0, 7'd16, 16'hFFFF);
        send_beat(fve_pkg::FUNC_BIN, 16'hFFFF, 1'b0, 7'd127, 16'hFFFF);
        // Thermometer, partial and saturated at the width.
        send_beat(fve_pkg::FUNC_THERM, 16'd5, 1'b0, 7'd8, 16'd9);
        send_beat(fve_pkg::FUNC_THERM, 16'hFFFF, 1'b0, 7'd64, 16'hFFFF);
        send_beat(fve_pkg::FUNC_THERM, 16'd1, 1'b0, 7'd1, 16'd1);
        // Square-root thermometer.
        send_beat(fve_pkg::FUNC_SQRT, 16'd17, 1'b0, 7'd10, 16'd20);
        send_beat(fve_pkg::FUNC_SQRT, 16'hFFFF, 1'b0, 7'd64, 16'hFFFF);
        // One-hot inside the width, past the width, and at the top element.
        send_beat(fve_pkg::FUNC_ONEHOT, 16'd3, 1'b0, 7'd8, 16'd10);
        send_beat(fve_pkg::FUNC_ONEHOT, 16'd9, 1'b0, 7'd8, 16'd10);
        send_beat(fve_pkg::FUNC_ONEHOT, 16'd63, 1'b0, 7'd64, 16'd100);
        // Not available across kinds and widths, an empty run among them.
        send_beat(fve_pkg::FUNC_FRAC, 16'hFFFF, 1'b1, 7'd0, 16'd0);
        send_beat(fve_pkg::FUNC_BIN, 16'd0, 1'b1, 7'd5, 16'd1);
        send_beat(FUNC_BAD_LAST, 16'd7, 1'b1, 7'd3, 16'd1);
        send_beat(fve_pkg::FUNC_THERM, 16'd2, 1'b1, 7'd0, 16'd3);
        send_beat(fve_pkg::FUNC_SQRT, 16'd2, 1'b1, 7'd100, 16'd3);
        // Out of range, unknown kinds (one with a zero width), and an empty run.
        send_beat(fve_pkg::FUNC_THERM, 16'd10, 1'b0, 7'd8, 16'd9);
        send_beat(FUNC_BAD_FIRST, 16'd4, 1'b0, 7'd8, 16'd9);
        send_beat(FUNC_BAD_LAST, 16'd0, 1'b0, 7'd0, 16'd0);
        send_beat(fve_pkg::FUNC_BIN, 16'd3, 1'b0, 7'd0, 16'd3);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= 80 && n < 130);
            roll = $urandom_range(99);
            if (roll < 15) begin
                // Noise: every field drawn over its full encoding.
                func      = 3'($urandom);
                value     = 16'($urandom);
                na        = 1'($urandom);
                width     = 7'($urandom);
                max_value = 16'($urandom);
            end else begin
                func = 3'($urandom_range(fve_pkg::FUNC_ONEHOT, fve_pkg::FUNC_FRAC));
                max_value = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                                     : 16'($urandom_range(300, 1));
                value = 16'($urandom_range(max_value, 0));
                roll = $urandom_range(99);
                if (roll < 70) begin
                    width = 7'($urandom_range(16, 1));
                end else if (roll < 88) begin
                    width = 7'($urandom_range(64, 17));
                end else if (roll < 95) begin
                    width = 7'($urandom_range(127, 65));
                end else begin
                    width = 7'd0;
                end
                // Half the time, draw the hot element within the widest run (0 to 63).
                if (func == fve_pkg::FUNC_ONEHOT && $urandom_range(1) == 1) begin
                    value = 16'($urandom_range(63, 0));
                    if (max_value < value) begin
                        max_value = value;
                    end
                end
                na = ($urandom_range(9) == 0);
            end
            send_beat(func, value, na, width, max_value);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d inputs to %0d beats; NA %0d, over range %0d, bad kind %0d.",
                 sb.items_seen, sb.beats_seen, sb.na_count, sb.range_count,
                 sb.bad_kind_count);
        $display("Inputs per kind: frac %0d, bin %0d, therm %0d, sqrt %0d, one-hot %0d.",
                 sb.kind_count[fve_pkg::FUNC_FRAC], sb.kind_count[fve_pkg::FUNC_BIN],
                 sb.kind_count[fve_pkg::FUNC_THERM], sb.kind_count[fve_pkg::FUNC_SQRT],
                 sb.kind_count[fve_pkg::FUNC_ONEHOT]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
